// ===== hw/rtl/ed7_pkg.sv =====
package ed7_pkg;

  localparam int ED7_MAX_WIDTH = 2048;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GREY_MODE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(2);

  localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd480;

  localparam int LUMA_R     = 299;
  localparam int LUMA_G     = 587;
  localparam int LUMA_B     = 114;
  localparam int LUMA_RECIP = 268436;
  localparam int LUMA_SHIFT = 28;

  localparam int ITEM_Q_DEPTH = 4;
  localparam int RES_Q_DEPTH  = 2;

  typedef struct packed {
    logic        grey;
    logic        first_row;
    logic        end_row;
    logic        end_frame;
    logic [15:0] row;
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [7:0]  c2;
  } ed7_item_t;

  typedef struct packed {
    logic [6:0]  level_code;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [10:0] column;
    logic [15:0] row;
    logic        last_in_row;
    logic        last_in_frame;
  } ed7_result_t;

  // entry: {level[6:0], reconstructed value[7:0]} for a clamped value 0..255
  typedef logic [14:0] qtab_t [256];

  function automatic qtab_t make_qtab(input int levels);
    qtab_t tab;
    int    n;
    int    rec;
    for (int t = 0; t < 256; t++) begin
      n   = (2 * t * levels + 255) / 510;
      rec = 0;
      for (int r = 0; r < 256; r++) begin
        if (r * levels <= n * 255) rec = r;
      end
      tab[t] = {7'(n), 8'(rec)};
    end
    return tab;
  endfunction

  localparam qtab_t QTAB_L3   = make_qtab(3);
  localparam qtab_t QTAB_L7   = make_qtab(7);
  localparam qtab_t QTAB_L127 = make_qtab(127);

endpackage

// ===== hw/rtl/ed7_fifo.sv =====
module ed7_fifo import ed7_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [AW:0]      count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (AW+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = data_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");

endmodule

// ===== hw/rtl/ed7_front.sv =====
module ed7_front import ed7_pkg::*; #(
  parameter int  MAX_WIDTH = ED7_MAX_WIDTH,
  localparam int XW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          restart_i,
  input  logic          grey_mode_i,
  input  logic [11:0]   image_width_i,
  input  logic [15:0]   image_height_i,
  input  logic          push_i,
  output logic          full_o,
  input  logic [7:0]    in_red_i,
  input  logic [7:0]    in_green_i,
  input  logic [7:0]    in_blue_i,
  input  logic          item_ready_i,
  output logic          item_push_o,
  output ed7_item_t     item_o,
  output logic [XW-1:0] item_x_o
);

  localparam int WW = (XW > 12) ? XW + 1 : 13;

  logic [WW-1:0] w_raw, w_eff;
  logic [XW-1:0] last_col;
  logic [15:0]   last_row;
  logic [XW-1:0] col_q;
  logic [15:0]   row_q;
  logic          accept, end_row, end_frame;

  logic          s1_valid_q;
  ed7_item_t     s1_item_q;
  logic [XW-1:0] s1_x_q;
  logic [17:0]   s1_sum_q;
  logic [36:0]   luma_prod;

  assign w_raw = WW'(image_width_i);

  always_comb begin
    if (w_raw == '0) begin
      w_eff = WW'(1);
    end else if (w_raw > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
  end

  assign last_col  = XW'(w_eff - WW'(1));
  assign last_row  = (image_height_i == '0) ? '0 : image_height_i - 16'd1;
  assign end_row   = (col_q == last_col);
  assign end_frame = end_row && (row_q == last_row);

  assign full_o      = s1_valid_q && !item_ready_i;
  assign accept      = push_i && !full_o;
  assign item_push_o = s1_valid_q && item_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (restart_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (accept) begin
        if (end_row) begin
          col_q <= '0;
          row_q <= end_frame ? '0 : row_q + 16'd1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (item_push_o) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q.grey      <= grey_mode_i;
      s1_item_q.first_row <= (row_q == '0);
      s1_item_q.end_row   <= end_row;
      s1_item_q.end_frame <= end_frame;
      s1_item_q.row       <= row_q;
      s1_item_q.c0        <= in_red_i;
      s1_item_q.c1        <= in_green_i;
      s1_item_q.c2        <= in_blue_i;
      s1_x_q              <= col_q;
      s1_sum_q            <= 18'(in_red_i) * 18'(LUMA_R) + 18'(in_green_i) * 18'(LUMA_G)
                           + 18'(in_blue_i) * 18'(LUMA_B);
    end
  end

  assign luma_prod = 37'(s1_sum_q) * 37'(LUMA_RECIP);

  always_comb begin
    item_o = s1_item_q;
    if (s1_item_q.grey) begin
      item_o.c0 = luma_prod[LUMA_SHIFT +: 8];
    end
  end

  assign item_x_o = s1_x_q;

  a_row_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_row |=> col_q == '0) else $error("column did not wrap at row end");

endmodule

// ===== hw/rtl/ed7_back.sv =====
module ed7_back import ed7_pkg::*; #(
  parameter int  MAX_WIDTH = ED7_MAX_WIDTH,
  localparam int XW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          restart_i,
  input  logic          q_valid_i,
  input  ed7_item_t     q_item_i,
  input  logic [XW-1:0] q_x_i,
  output logic          q_pop_o,
  input  logic          res_ready_i,
  output logic          res_push_o,
  output ed7_result_t   res_o
);

  localparam int ERR_W  = 11;
  localparam int WORD_W = 3 * ERR_W;
  localparam int SUM_W  = 14;

  typedef logic signed [ERR_W-1:0] err_t;

  logic [WORD_W-1:0] mem_q [MAX_WIDTH];
  logic [WORD_W-1:0] rdata_q, fwd_data_q, mem_word;
  logic              fwd_q;

  logic          a_valid_q;
  ed7_item_t     a_item_q;
  logic [XW-1:0] a_x_q;
  logic          fire, load;

  err_t rc_q [3];
  err_t bp0_q [3];
  err_t bp1_q [3];

  logic              defer_valid_q;
  logic [XW-1:0]     defer_addr_q;
  logic [WORD_W-1:0] defer_data_q;

  logic [7:0]              chan_c [3];
  err_t                    below [3];
  logic signed [SUM_W-1:0] sum [3];
  logic [7:0]              t [3];
  logic [14:0]             qent [3];
  logic [6:0]              nq [3];
  logic [7:0]              rec [3];
  err_t                    e [3];
  err_t                    pend [3];
  err_t                    wxm1 [3];
  err_t                    rc_n [3];
  logic                    active [3];

  logic [WORD_W-1:0] pend_word, wxm1_word, fwd_sel_data, wr_data;
  logic [XW-1:0]     x_left, wr_addr;
  logic              left_wr, wr_en, fwd_sel;

  assign fire    = a_valid_q && res_ready_i;
  assign load    = q_valid_i && (!a_valid_q || fire);
  assign q_pop_o = load;

  assign mem_word = fwd_q ? fwd_data_q : rdata_q;

  always_comb begin
    chan_c[0] = a_item_q.c0;
    chan_c[1] = a_item_q.c1;
    chan_c[2] = a_item_q.c2;
    for (int i = 0; i < 3; i++) begin
      below[i] = a_item_q.first_row ? '0 : err_t'(mem_word[ERR_W*i +: ERR_W]);
      sum[i]   = signed'({2'b00, chan_c[i], 4'b0000}) + SUM_W'(rc_q[i]) + SUM_W'(below[i]);
      if (sum[i][SUM_W-1]) begin
        t[i] = 8'd0;
      end else if (sum[i][12]) begin
        t[i] = 8'd255;
      end else begin
        t[i] = sum[i][11:4];
      end
    end
    qent[0]   = a_item_q.grey ? QTAB_L127[t[0]] : QTAB_L3[t[0]];
    qent[1]   = QTAB_L7[t[1]];
    qent[2]   = QTAB_L3[t[2]];
    active[0] = 1'b1;
    active[1] = !a_item_q.grey;
    active[2] = !a_item_q.grey;
    for (int i = 0; i < 3; i++) begin
      nq[i]   = active[i] ? qent[i][14:8] : '0;
      rec[i]  = active[i] ? qent[i][7:0] : '0;
      e[i]    = active[i] ? err_t'(signed'({1'b0, t[i]}) - signed'({1'b0, rec[i]})) : '0;
      pend[i] = bp1_q[i] + (e[i] <<< 2) + e[i];
      wxm1[i] = bp0_q[i] + (e[i] <<< 1) + e[i];
      rc_n[i] = (e[i] <<< 3) - e[i];
    end
  end

  assign pend_word = {pend[2], pend[1], pend[0]};
  assign wxm1_word = {wxm1[2], wxm1[1], wxm1[0]};
  assign x_left    = XW'(a_x_q - 1'b1);
  assign left_wr   = fire && (a_x_q != '0);
  assign wr_en     = left_wr || defer_valid_q;
  assign wr_addr   = left_wr ? x_left : defer_addr_q;
  assign wr_data   = left_wr ? wxm1_word : defer_data_q;

  // newest write to the address being read wins
  always_comb begin
    fwd_sel      = 1'b1;
    fwd_sel_data = pend_word;
    priority if (fire && a_item_q.end_row && (a_x_q == q_x_i)) begin
      fwd_sel_data = pend_word;
    end else if (left_wr && (x_left == q_x_i)) begin
      fwd_sel_data = wxm1_word;
    end else if (defer_valid_q && (defer_addr_q == q_x_i)) begin
      fwd_sel_data = defer_data_q;
    end else begin
      fwd_sel = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (load) begin
      rdata_q <= mem_q[q_x_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q     <= 1'b0;
      defer_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        rc_q[i]  <= '0;
        bp0_q[i] <= '0;
        bp1_q[i] <= '0;
      end
    end else begin
      if (load) begin
        a_valid_q <= 1'b1;
      end else if (fire) begin
        a_valid_q <= 1'b0;
      end
      defer_valid_q <= fire && a_item_q.end_row;
      for (int i = 0; i < 3; i++) begin
        if (restart_i || (fire && a_item_q.end_row)) begin
          rc_q[i]  <= '0;
          bp0_q[i] <= '0;
          bp1_q[i] <= '0;
        end else if (fire) begin
          rc_q[i]  <= rc_n[i];
          bp0_q[i] <= pend[i];
          bp1_q[i] <= e[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      a_item_q   <= q_item_i;
      a_x_q      <= q_x_i;
      fwd_q      <= fwd_sel;
      fwd_data_q <= fwd_sel_data;
    end
    if (fire) begin
      defer_addr_q <= a_x_q;
      defer_data_q <= pend_word;
    end
  end

  always_comb begin
    if (a_item_q.grey) begin
      res_o.level_code = nq[0];
      res_o.red        = rec[0];
      res_o.green      = rec[0];
      res_o.blue       = rec[0];
    end else begin
      res_o.level_code = {nq[0][1:0], nq[1][2:0], nq[2][1:0]};
      res_o.red        = rec[0];
      res_o.green      = rec[1];
      res_o.blue       = rec[2];
    end
    res_o.column        = 11'(a_x_q);
    res_o.row           = a_item_q.row;
    res_o.last_in_row   = a_item_q.end_row;
    res_o.last_in_frame = a_item_q.end_frame;
  end

  assign res_push_o = fire;

  a_defer_port_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    defer_valid_q |-> !left_wr) else $error("row-end write collides with left write");

  a_row_end_clears_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && a_item_q.end_row |=> rc_q[0] == '0 && rc_q[1] == '0 && rc_q[2] == '0)
    else $error("right carry survived row end");

endmodule

// ===== hw/rtl/error_diffusion_dither_7bit.sv =====
// Floyd-Steinberg ditherer from 24-bit RGB to 7-bit codes (2-3-2 colour or 7-bit grey).
// Configuration: write cfg_data_i to register cfg_index_i (0 grey mode, 1 image width,
//   2 image height) with cfg_we_i high; any write to a valid index restarts the frame.
//   Write only while no pixel is in flight.
// Input: pixels in raster order on in_red_i/in_green_i/in_blue_i; a transaction
//   completes at a clock edge with push high and full low.
// Output: the oldest result sits on the result ports while empty is low; a transaction
//   completes at a clock edge with pop high and empty low.
// Throughput: one pixel per clock, sustained while pop is held high. The left-to-right
//   error recurrence closes through the carry registers of the back end; the row store
//   is one memory with one write and one registered read port.
// Path: each pixel passes in order through the luma stage, the item queue, the
//   row-store read and the result queue.
// Stall: while pop is held low the result queue fills, then the back end, the item
//   queue and the luma stage hold, and full rises; nothing is lost.
// Reset: registers return to grey mode 0, width 640, height 480; queues empty,
//   position and carried errors cleared. The row store needs no clearing: the first
//   row of a frame ignores what it reads from it.
module error_diffusion_dither_7bit import ed7_pkg::*; #(
  parameter int  MAX_WIDTH = ED7_MAX_WIDTH,
  localparam int XW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            in_red_i,
  input  logic [7:0]            in_green_i,
  input  logic [7:0]            in_blue_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [6:0]            level_code_o,
  output logic [7:0]            out_red_o,
  output logic [7:0]            out_green_o,
  output logic [7:0]            out_blue_o,
  output logic [10:0]           column_o,
  output logic [15:0]           row_o,
  output logic                  last_in_row_o,
  output logic                  last_in_frame_o
);

  localparam int QW = $bits(ed7_item_t) + XW;
  localparam int RW = $bits(ed7_result_t);

  logic        grey_mode_q;
  logic [11:0] image_width_q;
  logic [15:0] image_height_q;
  logic        restart;

  ed7_item_t     f_item, b_item;
  logic [XW-1:0] f_x, b_x;
  logic          f_push, q_full, q_empty, q_pop;
  logic [QW-1:0] q_out;

  ed7_result_t   b_res, res;
  logic          res_push, res_full;
  logic [RW-1:0] res_out;

  always_comb begin
    unique case (cfg_index_i)
      REG_GREY_MODE, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: restart = cfg_we_i;
      default: restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grey_mode_q    <= 1'b0;
      image_width_q  <= RST_IMAGE_WIDTH;
      image_height_q <= RST_IMAGE_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_GREY_MODE:    grey_mode_q    <= cfg_data_i[0];
        REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[11:0];
        REG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  ed7_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .restart_i     (restart),
    .grey_mode_i   (grey_mode_q),
    .image_width_i (image_width_q),
    .image_height_i(image_height_q),
    .push_i        (push),
    .full_o        (full),
    .in_red_i,
    .in_green_i,
    .in_blue_i,
    .item_ready_i  (!q_full),
    .item_push_o   (f_push),
    .item_o        (f_item),
    .item_x_o      (f_x)
  );

  ed7_fifo #(
    .WIDTH(QW),
    .DEPTH(ITEM_Q_DEPTH)
  ) u_item_q (
    .clk_i,
    .rst_ni,
    .push_i (f_push),
    .data_i ({f_item, f_x}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_out),
    .empty_o(q_empty)
  );

  assign b_item = q_out[QW-1:XW];
  assign b_x    = q_out[XW-1:0];

  ed7_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .restart_i  (restart),
    .q_valid_i  (!q_empty),
    .q_item_i   (b_item),
    .q_x_i      (b_x),
    .q_pop_o    (q_pop),
    .res_ready_i(!res_full),
    .res_push_o (res_push),
    .res_o      (b_res)
  );

  ed7_fifo #(
    .WIDTH(RW),
    .DEPTH(RES_Q_DEPTH)
  ) u_res_q (
    .clk_i,
    .rst_ni,
    .push_i (res_push),
    .data_i (b_res),
    .full_o (res_full),
    .pop_i  (pop && !empty),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign res             = res_out;
  assign level_code_o    = res.level_code;
  assign out_red_o       = res.red;
  assign out_green_o     = res.green;
  assign out_blue_o      = res.blue;
  assign column_o        = res.column;
  assign row_o           = res.row;
  assign last_in_row_o   = res.last_in_row;
  assign last_in_frame_o = res.last_in_frame;

endmodule
